[sv/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU key/value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CAP_W          = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_status_t;

endpackage

[sv/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a request, scan all slots, drain the read, commit.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfu_pkg::dp_status_t status,
  output lfu_pkg::ctrl_cmd_t  cmd
);

  lfu_pkg::state_t state;
  lfu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN: begin
        state_next = lfu_pkg::ST_COMMIT;
      end
      lfu_pkg::ST_COMMIT: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/lfu_dp.sv]
// ----------------------------------------------------------------------------
// lfu_dp
// Slot memories, valid bits, scan accumulators and result register.
// ----------------------------------------------------------------------------
module lfu_dp #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lfu_pkg::ctrl_cmd_t                cmd,
  output lfu_pkg::dp_status_t               status,
  input  logic                              cfg_write,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              command,
  input  logic signed [lfu_pkg::DATA_W-1:0] key,
  input  logic signed [lfu_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic signed [lfu_pkg::DATA_W-1:0] read_value,
  output logic                              evicted,
  output logic signed [lfu_pkg::DATA_W-1:0] evicted_key
);

  localparam int unsigned DW    = lfu_pkg::DATA_W;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NV_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (NV_W > lfu_pkg::CAP_W) ? NV_W : lfu_pkg::CAP_W;

  logic [lfu_pkg::CAP_W-1:0] capacity;

  logic [DW-1:0]         key_mem   [ENTRIES];
  logic [DW-1:0]         value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid;

  logic [DW-1:0]         key_q;
  logic [DW-1:0]         value_q;
  logic [COUNT_BITS-1:0] count_q;

  logic          req_cmd;
  logic [DW-1:0] req_key;
  logic [DW-1:0] req_value;

  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_pend;

  logic                  match_found;
  logic [IDX_W-1:0]      match_idx;
  logic [DW-1:0]         match_value;
  logic [COUNT_BITS-1:0] match_count;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  vict_found;
  logic [IDX_W-1:0]      vict_idx;
  logic [DW-1:0]         vict_key;
  logic [COUNT_BITS-1:0] best;
  logic [NV_W-1:0]       nvalid;

  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  need_evict;
  logic                  do_evict;
  logic                  do_insert;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] bumped;

  assign status.scan_last = (scan_addr == IDX_W'(ENTRIES - 1));
  assign status.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign need_evict = (CMP_W'(nvalid) >= cap_eff) && vict_found;
  assign do_insert  = (req_cmd == lfu_pkg::CMD_PUT) && !match_found;
  assign do_evict   = do_insert && need_evict;
  assign bumped     = (&match_count) ? match_count : match_count + COUNT_BITS'(1);

  always_comb begin
    if (match_found) begin
      wr_idx = match_idx;
    end else if (need_evict) begin
      wr_idx = vict_idx;
    end else begin
      wr_idx = free_idx;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cmd   <= command;
      req_key   <= key;
      req_value <= value;
    end
  end

  // slot memories: one read and one write address per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      key_q   <= key_mem[scan_addr];
      value_q <= value_mem[scan_addr];
      count_q <= count_mem[scan_addr];
    end
    if (cmd.commit) begin
      if (match_found) begin
        count_mem[wr_idx] <= bumped;
        if (req_cmd == lfu_pkg::CMD_PUT) begin
          value_mem[wr_idx] <= req_value;
        end
      end else if (do_insert) begin
        key_mem[wr_idx]   <= req_key;
        value_mem[wr_idx] <= req_value;
        count_mem[wr_idx] <= COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit && do_insert) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      scan_addr <= '0;
    end else begin
      rd_pend <= cmd.scan;
      if (cmd.accept) begin
        scan_addr <= '0;
      end else if (cmd.scan && !status.scan_last) begin
        scan_addr <= scan_addr + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx <= scan_addr;
    end
  end

  // scan accumulators: first match, first free slot, lowest-count victim
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      vict_found  <= 1'b0;
      nvalid      <= '0;
    end else if (rd_pend) begin
      if (entry_valid[rd_idx]) begin
        nvalid <= nvalid + NV_W'(1);
        if (!match_found && key_q == req_key) begin
          match_found <= 1'b1;
          match_idx   <= rd_idx;
          match_value <= value_q;
          match_count <= count_q;
        end
        if (!vict_found || count_q < best) begin
          vict_found <= 1'b1;
          vict_idx   <= rd_idx;
          vict_key   <= key_q;
          best       <= count_q;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit     <= match_found;
      evicted <= do_evict;
      if (req_cmd == lfu_pkg::CMD_GET) begin
        read_value <= match_found ? match_value : '1;
      end else begin
        read_value <= '0;
      end
      evicted_key <= do_evict ? vict_key : '0;
    end
  end

endmodule

[sv/lfu_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lfu_key_value_cache
// Least-frequently-used key/value cache with a scanning controller.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one request (command, key, value).
// Output channel: out_valid/out_stall carry one result per request
// (hit, read_value, evicted, evicted_key).
// Config: cfg_write loads cfg_data into the capacity register. The user
// must write it only while idle; the block itself does not enforce this.
// Each accepted request reads the slot memories one slot per cycle in the
// scan state, takes a drain state for the last read, then commits to the
// result register. The single memory read port forces this slot-by-slot
// scan. A new request is accepted in the cycle after commit, so no new
// request is taken while one is in flight. A finished result waits in the
// output register while the next request scans; commit waits only if that
// register is still stalled. Reset clears the valid bits and out_valid and
// sets capacity to 16; key, value and count memories are not cleared.
// ----------------------------------------------------------------------------
module lfu_key_value_cache #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic signed [lfu_pkg::DATA_W-1:0] key,
  input  logic signed [lfu_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic signed [lfu_pkg::DATA_W-1:0] read_value,
  output logic                              evicted,
  output logic signed [lfu_pkg::DATA_W-1:0] evicted_key,
  input  logic                              cfg_write,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data
);

  lfu_pkg::ctrl_cmd_t  cmd;
  lfu_pkg::dp_status_t status;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .command     (command),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("commit overwrote a stalled result");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted) |-> (evicted_key == '0))
    else $error("evicted_key nonzero without eviction");

endmodule
